// ===== rtl/sgtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Semigraphics tile plotter package
// Shared types, command codes and helpers for the plotter front end, back end
// and top level.
// ----------------------------------------------------------------------------
package sgtp_pkg;

	// Default screen size in cells.
	localparam int COLS_DEF = 32;
	localparam int ROWS_DEF = 16;

	// Cell coordinates and rectangle ends are carried with room for 0..127.
	localparam int COORD_W = 7;

	// Command codes on the input channel.
	localparam logic [2:0] CMD_CLEAR    = 3'd0;
	localparam logic [2:0] CMD_SET_PAL  = 3'd1;
	localparam logic [2:0] CMD_SET_CODE = 3'd2;
	localparam logic [2:0] CMD_SET_PIX  = 3'd3;
	localparam logic [2:0] CMD_FILL     = 3'd4;
	localparam logic [2:0] CMD_PEEK     = 3'd5;

	typedef struct packed {
		logic [2:0] cmd;
		logic [5:0] pos_x;
		logic [5:0] pos_y;
		logic [5:0] rect_width;
		logic [4:0] rect_height;
		logic [7:0] char_code;
		logic       pixel_on;
		logic       use_second_palette;
	} cmd_t;

	typedef struct packed {
		logic [7:0] code_read;
		logic       palette_read;
		logic       status;
	} rsp_t;

	// Work kinds after classification by the front end.
	typedef enum logic [2:0] {
		OP_NONE     = 3'd0,
		OP_SET_PAL  = 3'd1,
		OP_SET_CODE = 3'd2,
		OP_PIXEL    = 3'd3,
		OP_FILL     = 3'd4,
		OP_PEEK     = 3'd5,
		OP_CLEAR    = 3'd6
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic               status;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col_end;
		logic [COORD_W-1:0] row_end;
		logic [2:0]         bit_sel;
		logic               pixel_on;
		logic               pal;
		logic [7:0]         code;
	} op_t;

	// Status from the back end to the front end.
	typedef struct packed {
		logic take;
		logic init_busy;
	} back_stat_t;

	// Bit of the character code that holds a pixel, from the row within the
	// cell and the column within the cell.
	function automatic logic [2:0] pixel_bit(input logic [1:0] r, input logic xl);
		logic [2:0] b;
		b = 3'd0;
		unique case (r)
			2'd0: b = xl ? 3'd4 : 3'd5;
			2'd1: b = xl ? 3'd2 : 3'd3;
			2'd2: b = xl ? 3'd0 : 3'd1;
			default: b = 3'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/sgtp_front.sv =====
// ----------------------------------------------------------------------------
// Semigraphics tile plotter front end
// Accepts commands, checks coordinates, works out cell positions and clipped
// rectangle ends, and queues the resulting work for the back end.
// ----------------------------------------------------------------------------
module sgtp_front #(
	parameter int COLS = 32,
	parameter int ROWS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  sgtp_pkg::cmd_t      cmd,
	input  sgtp_pkg::back_stat_t stat,
	output logic                op_valid,
	output sgtp_pkg::op_t       op
);
	import sgtp_pkg::*;

	localparam logic [COORD_W-1:0] COLS_C  = COORD_W'(COLS);
	localparam logic [COORD_W-1:0] ROWS_C  = COORD_W'(ROWS);
	localparam logic [7:0]         PIX_X_C = 8'(2 * COLS);
	localparam logic [7:0]         PIX_Y_C = 8'(3 * ROWS);

	op_t                ent_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;
	logic               pop;
	op_t                cls;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;
	logic [COORD_W-1:0] xe;
	logic [COORD_W-1:0] ye;
	logic               cell_ok;
	logic               pix_ok;
	logic [11:0]        prod;
	logic [4:0]         q3;
	logic [5:0]         rem6;

	assign cmd_stall = (cnt_q == 2'd2) || stat.init_busy;
	assign push      = cmd_valid && !cmd_stall;
	assign pop       = stat.take;
	assign op_valid  = (cnt_q != 2'd0);
	assign op        = ent_q[rd_ptr_q];

	// Classification.
	always_comb begin
		cx      = {1'b0, cmd.pos_x};
		cy      = {1'b0, cmd.pos_y};
		cell_ok = (cx < COLS_C) && (cy < ROWS_C);
		pix_ok  = ({2'b0, cmd.pos_x} < PIX_X_C) && ({2'b0, cmd.pos_y} < PIX_Y_C);
		xe      = cx + {1'b0, cmd.rect_width};
		ye      = cy + {2'b0, cmd.rect_height};
		if (xe > COLS_C) begin
			xe = COLS_C;
		end
		if (ye > ROWS_C) begin
			ye = ROWS_C;
		end
		// Division by three through a reciprocal, exact for six-bit rows.
		prod = 12'(cmd.pos_y) * 12'd43;
		q3   = prod[11:7];
		rem6 = cmd.pos_y - 6'(6'(q3) * 6'd3);

		cls          = '0;
		cls.kind     = OP_NONE;
		cls.col      = cx;
		cls.row      = cy;
		cls.col_end  = xe;
		cls.row_end  = ye;
		cls.pixel_on = cmd.pixel_on;
		cls.pal      = cmd.use_second_palette;
		cls.code     = cmd.char_code;
		cls.bit_sel  = pixel_bit(rem6[1:0], cmd.pos_x[0]);
		unique case (cmd.cmd)
			CMD_CLEAR: begin
				cls.kind    = OP_CLEAR;
				cls.col     = '0;
				cls.row     = '0;
				cls.col_end = COLS_C;
				cls.row_end = ROWS_C;
				cls.pal     = 1'b0;
			end
			CMD_SET_PAL: begin
				cls.kind   = cell_ok ? OP_SET_PAL : OP_NONE;
				cls.status = !cell_ok;
			end
			CMD_SET_CODE: begin
				cls.kind   = cell_ok ? OP_SET_CODE : OP_NONE;
				cls.status = !cell_ok;
			end
			CMD_SET_PIX: begin
				cls.kind   = pix_ok ? OP_PIXEL : OP_NONE;
				cls.status = !pix_ok;
				cls.col    = {2'b0, cmd.pos_x[5:1]};
				cls.row    = {2'b0, q3};
			end
			CMD_FILL: begin
				// An empty rectangle writes nothing and still reports done.
				if (!cell_ok) begin
					cls.status = 1'b1;
				end else if ((cmd.rect_width != '0) && (cmd.rect_height != '0)) begin
					cls.kind = OP_FILL;
				end
			end
			CMD_PEEK: begin
				cls.kind   = cell_ok ? OP_PEEK : OP_NONE;
				cls.status = !cell_ok;
			end
			default: begin
				cls.kind = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/sgtp_back.sv =====
// ----------------------------------------------------------------------------
// Semigraphics tile plotter back end
// Holds the code and palette stores and carries out queued work: single cell
// writes, pixel read-modify-write, peeks and cell-by-cell sweeps.
// ----------------------------------------------------------------------------
module sgtp_back #(
	parameter int COLS = 32,
	parameter int ROWS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	input  sgtp_pkg::op_t        op,
	output sgtp_pkg::back_stat_t stat,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output sgtp_pkg::rsp_t       rsp
);
	import sgtp_pkg::*;

	localparam int NCELLS = COLS * ROWS;
	localparam int AW     = $clog2(NCELLS);
	localparam int PROD_W = 2 * COORD_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ  = 3'b010,
		ST_SWEEP = 3'b100
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] c,
			input logic [COORD_W-1:0] r);
		logic [PROD_W-1:0] a;
		a = PROD_W'(r) * PROD_W'(COLS) + PROD_W'(c);
		return a[AW-1:0];
	endfunction

	logic [7:0]         code_mem [NCELLS];
	logic               pal_mem  [NCELLS];
	logic [7:0]         rd_code_q;
	logic               rd_pal_q;

	state_t             state_q;
	state_t             state_d;
	op_t                cur_q;
	logic               init_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               slot_free;
	logic               take;
	logic               we_code;
	logic               we_pal;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic [7:0]         wcode;
	logic               wpal;
	logic               rsp_load;
	rsp_t               rsp_d;
	logic               sweep_start;
	logic               sweep_done;
	logic [COORD_W-1:0] sw_end_col;
	logic [COORD_W-1:0] sw_end_row;
	logic [COORD_W-1:0] sw_start_col;
	logic [COORD_W-1:0] col_nxt;
	logic [COORD_W-1:0] row_nxt;
	logic [7:0]         mask;

	assign slot_free      = !rsp_valid_q || !rsp_stall;
	assign take           = (state_q == ST_IDLE) && op_valid && slot_free;
	assign stat.take      = take;
	assign stat.init_busy = init_q;
	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;

	assign sw_end_col   = init_q ? COORD_W'(COLS) : cur_q.col_end;
	assign sw_end_row   = init_q ? COORD_W'(ROWS) : cur_q.row_end;
	assign sw_start_col = init_q ? '0 : cur_q.col;
	assign col_nxt      = col_q + 1'b1;
	assign row_nxt      = row_q + 1'b1;
	assign mask         = 8'(8'd1 << cur_q.bit_sel);

	always_comb begin
		state_d     = state_q;
		we_code     = 1'b0;
		we_pal      = 1'b0;
		waddr       = cell_addr(cur_q.col, cur_q.row);
		raddr       = cell_addr(cur_q.col, cur_q.row);
		wcode       = cur_q.code;
		wpal        = cur_q.pal;
		rsp_load    = 1'b0;
		rsp_d       = '0;
		sweep_start = 1'b0;
		sweep_done  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				raddr = cell_addr(op.col, op.row);
				waddr = cell_addr(op.col, op.row);
				wcode = op.code;
				wpal  = op.pal;
				if (take) begin
					unique case (op.kind)
						OP_SET_PAL: begin
							we_pal   = 1'b1;
							rsp_load = 1'b1;
						end
						OP_SET_CODE: begin
							we_code  = 1'b1;
							rsp_load = 1'b1;
						end
						OP_PIXEL, OP_PEEK: begin
							state_d = ST_READ;
						end
						OP_FILL, OP_CLEAR: begin
							sweep_start = 1'b1;
							state_d     = ST_SWEEP;
						end
						default: begin
							rsp_load     = 1'b1;
							rsp_d.status = op.status;
						end
					endcase
				end
			end
			ST_READ: begin
				state_d  = ST_IDLE;
				rsp_load = 1'b1;
				if (cur_q.kind == OP_PIXEL) begin
					we_code = 1'b1;
					wcode   = cur_q.pixel_on ? (rd_code_q | mask) : (rd_code_q & ~mask);
				end else begin
					rsp_d.code_read    = rd_code_q;
					rsp_d.palette_read = rd_pal_q;
				end
			end
			ST_SWEEP: begin
				we_code = 1'b1;
				we_pal  = 1'b1;
				waddr   = cell_addr(col_q, row_q);
				wcode   = init_q ? 8'd0 : cur_q.code;
				wpal    = init_q ? 1'b0 : cur_q.pal;
				if ((col_nxt == sw_end_col) && (row_nxt == sw_end_row)) begin
					sweep_done = 1'b1;
					state_d    = ST_IDLE;
					rsp_load   = !init_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Stores: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we_code) begin
			code_mem[waddr] <= wcode;
		end
		if (we_pal) begin
			pal_mem[waddr] <= wpal;
		end
		rd_code_q <= code_mem[raddr];
		rd_pal_q  <= pal_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= op;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			init_q      <= 1'b1;
			col_q       <= '0;
			row_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sweep_done) begin
				init_q <= 1'b0;
			end
			if (sweep_start) begin
				col_q <= op.col;
				row_q <= op.row;
			end else if (state_q == ST_SWEEP) begin
				if (col_nxt == sw_end_col) begin
					col_q <= sw_start_col;
					row_q <= row_nxt;
				end else begin
					col_q <= col_nxt;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/semigraphics_tile_plotter_top.sv =====
// ----------------------------------------------------------------------------
// Semigraphics tile plotter
// Screen of COLS by ROWS cells with a character code and a palette bit each,
// driven by clear, palette, code, pixel, rectangle fill and peek commands.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the cmd channel (cmd_valid, cmd_stall, cmd) and
// every command gives exactly one transaction on the rsp channel (rsp_valid,
// rsp_stall, rsp). A transaction moves when valid is high and stall is low.
// The front end checks coordinates and queues up to two commands, so the
// sender keeps going while the back end works or the receiver stalls.
// The back end has a single store port and takes new work only when idle:
// set code and set palette write their cell straight away, out-of-range and
// unused commands only answer; set pixel and peek read first, then write or
// answer; a rectangle fill writes each covered cell in turn and clear writes
// every cell of the screen.
// After reset the back end sweeps the stores to zero, one cell per cycle,
// and cmd_stall is held high throughout. When the receiver stalls, the
// response is held and the back end stops taking new work once its output
// register is full; the queue then fills and raises cmd_stall.
// ----------------------------------------------------------------------------
module semigraphics_tile_plotter_top #(
	parameter int COLS = sgtp_pkg::COLS_DEF,
	parameter int ROWS = sgtp_pkg::ROWS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  sgtp_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sgtp_pkg::rsp_t rsp
);
	import sgtp_pkg::*;

	// Queue head towards the back end, and its take and reset-sweep status.
	logic       op_valid;
	op_t        op;
	back_stat_t stat;

	sgtp_front #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.stat     (stat),
		.op_valid (op_valid),
		.op       (op)
	);

	// The back end owns both stores and the response register.
	sgtp_back #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/sgtp_checker.sv =====
// ----------------------------------------------------------------------------
// Semigraphics tile plotter port checker
// Watches the top level's ports for handshake, response and reset behaviour.
// ----------------------------------------------------------------------------
module sgtp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input sgtp_pkg::cmd_t cmd,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input sgtp_pkg::rsp_t rsp
);

	// A stalled command stays offered and unchanged.
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("stalled command changed");

	// A stalled response stays offered and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// A command refused with status set never returns cell contents.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> (rsp.code_read == 8'd0) && !rsp.palette_read)
		else $error("flagged response carries data");

	// The store sweep after reset holds off commands.
	a_reset_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> cmd_stall)
		else $error("command accepted during reset sweep");

	// Nothing is answered before the first command can have been accepted.
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !rsp_valid)
		else $error("response right after reset");

endmodule

bind semigraphics_tile_plotter_top sgtp_checker u_sgtp_checker (.*);

// ===== dv/sgtp_screen_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Screen checker for the semigraphics tile plotter
// Watches both channels, keeps its own copy of the code and palette stores,
// works out the response to every accepted command and compares it, field by
// field, with the responses that the plotter returns.
// ----------------------------------------------------------------------------
module sgtp_screen_checker #(
	parameter int COLS = sgtp_pkg::COLS_DEF,
	parameter int ROWS = sgtp_pkg::ROWS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic           cmd_stall,
	input  sgtp_pkg::cmd_t cmd,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  sgtp_pkg::rsp_t rsp,
	output int             outstanding,
	output int             errors
);
	import sgtp_pkg::*;

	localparam int TILES = COLS * ROWS;

	logic [7:0] tile_code [TILES];
	logic       tile_pal  [TILES];
	rsp_t       awaited_rsp [$];
	int         fail_tally;

	// Applies one command to the screen copy and gives the response it earns.
	task automatic apply_to_screen(input cmd_t c, output rsp_t r);
		int x;
		int y;
		int x_end;
		int y_end;
		int idx;
		int shift;
		logic [7:0] mask;
		x = int'(c.pos_x);
		y = int'(c.pos_y);
		r = '0;
		case (c.cmd)
			CMD_CLEAR: begin
				for (int i = 0; i < TILES; i++) begin
					tile_code[i] = c.char_code;
					tile_pal[i] = 1'b0;
				end
			end
			CMD_SET_PAL: begin
				if (x < COLS && y < ROWS) begin
					tile_pal[y * COLS + x] = c.use_second_palette;
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_SET_CODE: begin
				if (x < COLS && y < ROWS) begin
					tile_code[y * COLS + x] = c.char_code;
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_SET_PIX: begin
				if (x < 2 * COLS && y < 3 * ROWS) begin
					// Top pixel pair holds bits 5 and 4, the left pixel the higher bit.
					idx = (y / 3) * COLS + x / 2;
					shift = 5 - 2 * (y % 3) - (x % 2);
					mask = 8'(1 << shift);
					if (c.pixel_on) begin
						tile_code[idx] = tile_code[idx] | mask;
					end else begin
						tile_code[idx] = tile_code[idx] & ~mask;
					end
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_FILL: begin
				if (x < COLS && y < ROWS) begin
					x_end = x + int'(c.rect_width);
					y_end = y + int'(c.rect_height);
					if (x_end > COLS) begin
						x_end = COLS;
					end
					if (y_end > ROWS) begin
						y_end = ROWS;
					end
					for (int j = y; j < y_end; j++) begin
						for (int i = x; i < x_end; i++) begin
							tile_code[j * COLS + i] = c.char_code;
							tile_pal[j * COLS + i] = c.use_second_palette;
						end
					end
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (x < COLS && y < ROWS) begin
					r.code_read = tile_code[y * COLS + x];
					r.palette_read = tile_pal[y * COLS + x];
				end else begin
					r.status = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Responses are checked before the command of the same edge is recorded,
	// so a response can only ever be matched against an older command.
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			awaited_rsp.delete();
			for (int i = 0; i < TILES; i++) begin
				tile_code[i] = 8'h00;
				tile_pal[i] = 1'b0;
			end
			fail_tally = 0;
			outstanding <= 0;
			errors <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					$error("response transaction with no command outstanding: code_read %0h",
						rsp.code_read);
					fail_tally++;
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.code_read !== want.code_read) begin
						$error("code_read: expected %0h, actual %0h", want.code_read,
							rsp.code_read);
						fail_tally++;
					end
					if (rsp.palette_read !== want.palette_read) begin
						$error("palette_read: expected %0h, actual %0h", want.palette_read,
							rsp.palette_read);
						fail_tally++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0h, actual %0h", want.status, rsp.status);
						fail_tally++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				apply_to_screen(cmd, want);
				awaited_rsp.push_back(want);
			end
			outstanding <= awaited_rsp.size();
			errors <= fail_tally;
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semigraphics tile plotter testbench
// Drives a directed run through the corner cases and then a long random run
// of commands under changing sender and receiver pacing; the screen checker
// beside the plotter predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
	import sgtp_pkg::*;

	localparam int COLS = COLS_DEF;
	localparam int ROWS = ROWS_DEF;

	// Command codes that the plotter does not use; they must still answer.
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 2000;
	localparam int PHASE_ITEMS  = 250;
	// Every command gives one response, so once the last one has arrived a
	// short quiet stretch is enough to catch any spurious transaction.
	localparam int DRAIN_CYCLES = 50;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int outstanding;
	int errors;

	// Pacing: percentage of cycles in which the sender idles before offering
	// a command, and in which the receiver stalls the response channel.
	int send_idle_pct;
	int rsp_stall_pct;

	always #10 clk = ~clk;

	semigraphics_tile_plotter_top #(
		.COLS(COLS),
		.ROWS(ROWS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	sgtp_screen_checker #(
		.COLS(COLS),
		.ROWS(ROWS)
	) screen_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.outstanding(outstanding),
		.errors     (errors)
	);

	// The receiver decides afresh on every edge whether to stall, so stalls
	// land on every phase of the plotter's work, fills and clears included.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	function automatic cmd_t command_of(input logic [2:0] op, input int x, input int y,
			input int w, input int h, input int code, input int on, input int pal);
		cmd_t c;
		c.cmd = op;
		c.pos_x = 6'(x);
		c.pos_y = 6'(y);
		c.rect_width = 6'(w);
		c.rect_height = 5'(h);
		c.char_code = 8'(code);
		c.pixel_on = 1'(on);
		c.use_second_palette = 1'(pal);
		return c;
	endfunction

	// Random commands are mostly well formed. About half of the coordinates
	// fall in a small corner of the screen, so that pixels, codes and palette
	// bits written there are read back by later peeks; the rest spread over
	// the screen, with a share outside it. Fills are mostly small, with the
	// occasional large one that runs over the right and bottom edges.
	function automatic cmd_t random_command();
		cmd_t c;
		int pick;
		int spot;
		pick = $urandom_range(99);
		spot = $urandom_range(99);
		c.rect_width = 6'($urandom_range(32));
		c.rect_height = 5'($urandom_range(16));
		c.char_code = 8'($urandom);
		c.pixel_on = 1'($urandom);
		c.use_second_palette = 1'($urandom);
		if (pick < 2) begin
			c.cmd = CMD_CLEAR;
		end else if (pick < 14) begin
			c.cmd = CMD_SET_PAL;
		end else if (pick < 28) begin
			c.cmd = CMD_SET_CODE;
		end else if (pick < 54) begin
			c.cmd = CMD_SET_PIX;
		end else if (pick < 68) begin
			c.cmd = CMD_FILL;
		end else if (pick < 96) begin
			c.cmd = CMD_PEEK;
		end else begin
			c.cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		end
		if (c.cmd == CMD_SET_PIX) begin
			if (spot < 50) begin
				c.pos_x = 6'($urandom_range(7));
				c.pos_y = 6'($urandom_range(5));
			end else if (spot < 90) begin
				c.pos_x = 6'($urandom_range(2 * COLS - 1));
				c.pos_y = 6'($urandom_range(3 * ROWS - 1));
			end else begin
				c.pos_x = 6'($urandom_range(63));
				c.pos_y = 6'($urandom_range(63));
			end
		end else begin
			if (spot < 45) begin
				c.pos_x = 6'($urandom_range(3));
				c.pos_y = 6'($urandom_range(1));
			end else if (spot < 85) begin
				c.pos_x = 6'($urandom_range(COLS - 1));
				c.pos_y = 6'($urandom_range(ROWS - 1));
			end else begin
				c.pos_x = 6'($urandom_range(63));
				c.pos_y = 6'($urandom_range(47));
			end
		end
		if (c.cmd == CMD_FILL && $urandom_range(15) != 0) begin
			c.rect_width = 6'($urandom_range(5));
			c.rect_height = 5'($urandom_range(3));
		end
		return c;
	endfunction

	// Offers one command and returns at the edge where the transaction
	// completes. Valid is only ever assigned once per edge: it stays high
	// straight into the next command unless the sender chooses to idle.
	task automatic push_command(input cmd_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) begin
			@(posedge clk);
		end
	endtask

	// Holds the sender back until the checker has nothing left outstanding.
	task automatic wait_for_responses();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int phase;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		rsp_stall_pct <= 0;
		send_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, with no idling on either side. The plotter sweeps
		// its stores after reset with cmd_stall high; the first transaction
		// simply waits for that to finish.
		push_command(command_of(CMD_PEEK, 0, 0, 0, 0, 8'h00, 0, 0));
		// Build the bottom-right cell pixel by pixel, then take one away.
		push_command(command_of(CMD_SET_CODE, COLS - 1, ROWS - 1, 32, 16, 8'h00, 1, 1));
		push_command(command_of(CMD_SET_PIX, 2 * COLS - 2, 3 * ROWS - 3, 0, 0, 8'hFF, 1, 0));
		push_command(command_of(CMD_SET_PIX, 2 * COLS - 1, 3 * ROWS - 3, 0, 0, 8'h00, 1, 1));
		push_command(command_of(CMD_SET_PIX, 2 * COLS - 2, 3 * ROWS - 2, 0, 0, 8'hFF, 1, 0));
		push_command(command_of(CMD_SET_PIX, 2 * COLS - 1, 3 * ROWS - 2, 0, 0, 8'h00, 1, 1));
		push_command(command_of(CMD_SET_PIX, 2 * COLS - 2, 3 * ROWS - 1, 0, 0, 8'hFF, 1, 0));
		push_command(command_of(CMD_SET_PIX, 2 * COLS - 1, 3 * ROWS - 1, 0, 0, 8'h00, 1, 1));
		push_command(command_of(CMD_PEEK, COLS - 1, ROWS - 1, 0, 0, 8'h00, 0, 0));
		push_command(command_of(CMD_SET_PIX, 2 * COLS - 1, 3 * ROWS - 1, 0, 0, 8'hFF, 0, 1));
		push_command(command_of(CMD_PEEK, COLS - 1, ROWS - 1, 0, 0, 8'h00, 0, 0));
		push_command(command_of(CMD_SET_PAL, COLS - 1, ROWS - 1, 0, 0, 8'hFF, 0, 1));
		push_command(command_of(CMD_PEEK, COLS - 1, ROWS - 1, 32, 16, 8'hFF, 1, 1));
		// Coordinates just off the screen, and the largest that the fields
		// hold, must be refused with nothing written.
		push_command(command_of(CMD_SET_CODE, COLS, 0, 0, 0, 8'hFF, 0, 0));
		push_command(command_of(CMD_SET_PAL, 0, ROWS, 0, 0, 8'h00, 0, 1));
		push_command(command_of(CMD_SET_PIX, 0, 3 * ROWS, 0, 0, 8'h00, 1, 0));
		push_command(command_of(CMD_PEEK, 63, 63, 0, 0, 8'h00, 0, 0));
		// A fill that overhangs both edges is clipped to the screen.
		push_command(command_of(CMD_FILL, COLS - 2, ROWS - 2, 32, 16, 8'hAA, 0, 1));
		push_command(command_of(CMD_PEEK, COLS - 1, ROWS - 1, 0, 0, 8'h00, 0, 0));
		// An empty fill, and a fill whose origin lies off the screen.
		push_command(command_of(CMD_FILL, 5, 5, 0, 3, 8'h55, 1, 1));
		push_command(command_of(CMD_FILL, 40, 0, 4, 4, 8'h55, 1, 1));
		push_command(command_of(CMD_SPARE_LO, 0, 0, 0, 0, 8'hFF, 1, 1));
		push_command(command_of(CMD_SPARE_HI, 63, 47, 32, 16, 8'hFF, 1, 1));
		// Clear always writes the first palette, whatever the command carries.
		push_command(command_of(CMD_CLEAR, 0, 0, 0, 0, 8'hFF, 1, 1));
		push_command(command_of(CMD_PEEK, COLS - 1, ROWS - 1, 0, 0, 8'h00, 0, 0));

		// Random part in phases of pacing: none, sender idling, receiver
		// stalling, then both together, twice over. Before the second round
		// the sender waits until every response has arrived, so the plotter
		// also starts from an empty queue in the middle of the run.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_ITEMS == 0) begin
				phase = n / PHASE_ITEMS;
				if (phase == 4) begin
					wait_for_responses();
				end
				case (phase % 4)
					0: begin
						send_idle_pct = 0;
						rsp_stall_pct <= 0;
					end
					1: begin
						send_idle_pct = 51;
						rsp_stall_pct <= 0;
					end
					2: begin
						send_idle_pct = 0;
						rsp_stall_pct <= 51;
					end
					default: begin
						send_idle_pct = 23;
						rsp_stall_pct <= 23;
					end
				endcase
			end
			push_command(random_command());
		end

		wait_for_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("semigraphics_tile_plotter_top test passed");
		end else begin
			$display("semigraphics_tile_plotter_top test failed");
		end
		$finish;
	end

	// A correct run takes well under a tenth of this, even with every clear
	// and large fill held up by receiver stalls.
	initial begin
		#10ms;
		$display("semigraphics_tile_plotter_top test failed");
		$finish;
	end

endmodule
